// ----- hw/rtl/pas_pkg.sv -----
// ----------------------------------------------------------------------------
// pas_pkg
// Shared types, constants and the arctangent table for the phasor adder.
// ----------------------------------------------------------------------------
package pas_pkg;

  localparam int unsigned AmpW   = 24;
  localparam int unsigned PhW    = 17;
  localparam int unsigned XW     = 36;   // datapath width of x and y
  localparam int unsigned ZW     = 34;   // angle width, 2^32 per turn
  localparam int unsigned GuardW = 6;
  localparam int unsigned MaxSteps = 24;

  localparam logic [29:0]         InvGain     = 30'd652032874;
  localparam logic signed [ZW-1:0] QuarterTurn = 34'sd1073741824;

  // One normalized operand
  typedef struct packed {
    logic [AmpW-1:0]        amp;
    logic [AmpW-1:0]        freq;
    logic signed [PhW-1:0]  ph;
  } pas_op_t;

  // Arctangent of 2^-i in 2^32 units per turn
  function automatic logic signed [ZW-1:0] pas_atan(input int unsigned i);
    logic signed [ZW-1:0] v;
    begin
      case (i)
        0:  v = 34'sd536870912;
        1:  v = 34'sd316933406;
        2:  v = 34'sd167458907;
        3:  v = 34'sd85004756;
        4:  v = 34'sd42667331;
        5:  v = 34'sd21354465;
        6:  v = 34'sd10679838;
        7:  v = 34'sd5340245;
        8:  v = 34'sd2670163;
        9:  v = 34'sd1335087;
        10: v = 34'sd667544;
        11: v = 34'sd333772;
        12: v = 34'sd166886;
        13: v = 34'sd83443;
        14: v = 34'sd41722;
        15: v = 34'sd20861;
        16: v = 34'sd10430;
        17: v = 34'sd5215;
        18: v = 34'sd2608;
        19: v = 34'sd1304;
        20: v = 34'sd652;
        21: v = 34'sd326;
        22: v = 34'sd163;
        23: v = 34'sd81;
        default: v = '0;
      endcase
      return v;
    end
  endfunction

endpackage

// ----- hw/rtl/pas_norm.sv -----
// ----------------------------------------------------------------------------
// pas_norm
// Registered normalization of one operand: magnitudes, phase fixup and wrap.
// ----------------------------------------------------------------------------
module pas_norm import pas_pkg::*; (
  input  logic                    clk_i,
  input  logic                    en_i,
  input  logic signed [AmpW-1:0]  amp_i,
  input  logic signed [AmpW-1:0]  freq_i,
  input  logic signed [15:0]      phase_i,
  output pas_op_t                 op_o
);

  logic              fneg, aneg;
  logic signed [17:0] p_neg, p_adj;
  logic [15:0]       p_low;
  logic [AmpW:0]     amp_ext, freq_ext;
  pas_op_t           op_d, op_q;

  // Negate phase for negative frequency, add a half turn on sign mismatch
  always_comb begin
    fneg     = freq_i[AmpW-1];
    aneg     = amp_i[AmpW-1];
    p_neg    = fneg ? -18'(phase_i) : 18'(phase_i);
    p_adj    = (fneg != aneg) ? (p_neg + 18'sd32768) : p_neg;
    p_low    = p_adj[15:0];
    amp_ext  = aneg ? -{amp_i[AmpW-1], amp_i} : {amp_i[AmpW-1], amp_i};
    freq_ext = fneg ? -{freq_i[AmpW-1], freq_i} : {freq_i[AmpW-1], freq_i};
    op_d.amp  = amp_ext[AmpW-1:0];
    op_d.freq = freq_ext[AmpW-1:0];
    op_d.ph   = (p_low > 16'd32768) ? {1'b1, p_low} : {1'b0, p_low};
  end

  // Hold when the pipeline is stalled
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      op_q <= op_d;
    end
  end

  assign op_o = op_q;

endmodule

// ----- hw/rtl/pas_cell.sv -----
// ----------------------------------------------------------------------------
// pas_cell
// One CORDIC micro-rotation with its output register, rotate or vector mode.
// ----------------------------------------------------------------------------
module pas_cell import pas_pkg::*; #(
  parameter int unsigned STEP   = 0,
  parameter bit          VECTOR = 1'b0
) (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic signed [XW-1:0] x_i,
  input  logic signed [XW-1:0] y_i,
  input  logic signed [ZW-1:0] z_i,
  output logic signed [XW-1:0] x_o,
  output logic signed [XW-1:0] y_o,
  output logic signed [ZW-1:0] z_o
);

  localparam logic signed [ZW-1:0] Atan = pas_atan(STEP);

  logic                 pos;
  logic signed [XW-1:0] dx, dy, x_d, y_d, x_q, y_q;
  logic signed [ZW-1:0] z_d, z_q;

  // Pick direction and rotate by atan(2^-STEP)
  always_comb begin
    pos = VECTOR ? y_i[XW-1] : ~z_i[ZW-1];
    dx  = y_i >>> STEP;
    dy  = x_i >>> STEP;
    if (pos) begin
      x_d = x_i - dx;
      y_d = y_i + dy;
      z_d = z_i - Atan;
    end else begin
      x_d = x_i + dx;
      y_d = y_i - dy;
      z_d = z_i + Atan;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q <= x_d;
      y_q <= y_d;
      z_q <= z_d;
    end
  end

  assign x_o = x_q;
  assign y_o = y_q;
  assign z_o = z_q;

endmodule

// ----- hw/rtl/phasor_add_subtract.sv -----
// ----------------------------------------------------------------------------
// phasor_add_subtract
// Adds or subtracts two sinusoids of equal frequency through CORDIC chains.
// ----------------------------------------------------------------------------
// Channel  Direction  Handshake           Payload
// in       sink       in_valid_i/stall_o  cmd, amp/freq/phase of a and b
// out      source     out_valid_o/stall_i amp_out, freq_out, phase_out, mismatch
//
// One transaction enters every cycle unless the pipeline holds. Its stages
// are the rotation chain, the vectoring chain and five fixed stages, with
// steps equal to CORDIC_STEPS capped at 24. The whole pipeline advances
// together; it holds only while a result sits in the output register under
// stall. Reset clears the valid bits only.
// ----------------------------------------------------------------------------
module phasor_add_subtract import pas_pkg::*; #(
  parameter int unsigned CORDIC_STEPS = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic                    cmd_i,
  input  logic signed [AmpW-1:0]  amp_a_i,
  input  logic signed [AmpW-1:0]  freq_a_i,
  input  logic signed [15:0]      phase_a_i,
  input  logic signed [AmpW-1:0]  amp_b_i,
  input  logic signed [AmpW-1:0]  freq_b_i,
  input  logic signed [15:0]      phase_b_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic [24:0]             amp_out_o,
  output logic [AmpW-1:0]         freq_out_o,
  output logic signed [PhW-1:0]   phase_out_o,
  output logic                    freq_mismatch_o
);

  localparam int unsigned NS = (CORDIC_STEPS > MaxSteps) ? MaxSteps : CORDIC_STEPS;
  localparam int unsigned NV = 2 * NS + 5;   // number of stages

  logic en;
  assign en         = ~(out_valid_o & out_stall_i);
  assign in_stall_o = ~en;

  // Valid bits, one per stage
  logic [NV-1:0] vld_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NV-2:0], in_valid_i};
    end
  end

  // Stage 0: normalize
  pas_op_t op_a, op_b;
  logic    cmd0_q;

  pas_norm u_norm_a (
    .clk_i, .en_i(en), .amp_i(amp_a_i), .freq_i(freq_a_i), .phase_i(phase_a_i),
    .op_o(op_a)
  );
  pas_norm u_norm_b (
    .clk_i, .en_i(en), .amp_i(amp_b_i), .freq_i(freq_b_i), .phase_i(phase_b_i),
    .op_o(op_b)
  );

  always_ff @(posedge clk_i) begin
    if (en) begin
      cmd0_q <= cmd_i;
    end
  end

  // Stage 1: gain prescale and quadrant pre-rotation
  function automatic logic [2*XW+ZW-1:0] pre_rot(input pas_op_t op);
    logic [59:0]          prod;
    logic signed [XW-1:0] a, x, y;
    logic signed [ZW-1:0] z;
    begin
      prod = 60'({op.amp, 6'b0}) * 60'(InvGain);
      a    = XW'(prod[59:30]);
      z    = {op.ph[PhW-1], op.ph, 16'b0};
      x    = a;
      y    = '0;
      if (z > QuarterTurn) begin
        x = '0;
        y = a;
        z = z - QuarterTurn;
      end else if (z < -QuarterTurn) begin
        x = '0;
        y = -a;
        z = z + QuarterTurn;
      end
      return {x, y, z};
    end
  endfunction

  logic signed [XW-1:0] ra_x [NS+1], ra_y [NS+1], rb_x [NS+1], rb_y [NS+1];
  logic signed [ZW-1:0] ra_z [NS+1], rb_z [NS+1];
  logic [AmpW-1:0]      fq_q [NS+1];
  logic                 mm_q [NS+1];
  logic                 cmd_q [NS+1];

  always_ff @(posedge clk_i) begin
    if (en) begin
      {ra_x[0], ra_y[0], ra_z[0]} <= pre_rot(op_a);
      {rb_x[0], rb_y[0], rb_z[0]} <= pre_rot(op_b);
      fq_q[0]  <= op_a.freq;
      mm_q[0]  <= (op_a.freq != op_b.freq);
      cmd_q[0] <= cmd0_q;
      for (int i = 1; i <= NS; i++) begin
        fq_q[i]  <= fq_q[i-1];
        mm_q[i]  <= mm_q[i-1];
        cmd_q[i] <= cmd_q[i-1];
      end
    end
  end

  // Rotation chains, both operands
  for (genvar g = 0; g < NS; g++) begin : g_rot
    pas_cell #(.STEP(g), .VECTOR(1'b0)) u_cell_a (
      .clk_i, .en_i(en),
      .x_i(ra_x[g]), .y_i(ra_y[g]), .z_i(ra_z[g]),
      .x_o(ra_x[g+1]), .y_o(ra_y[g+1]), .z_o(ra_z[g+1])
    );
    pas_cell #(.STEP(g), .VECTOR(1'b0)) u_cell_b (
      .clk_i, .en_i(en),
      .x_i(rb_x[g]), .y_i(rb_y[g]), .z_i(rb_z[g]),
      .x_o(rb_x[g+1]), .y_o(rb_y[g+1]), .z_o(rb_z[g+1])
    );
  end

  // Add or subtract, then pre-rotate into the right half plane
  logic signed [XW-1:0] sx, sy;
  logic signed [XW-1:0] v_x [NS+1], v_y [NS+1];
  logic signed [ZW-1:0] v_z [NS+1];
  logic [AmpW-1:0]      vfq_q [NS+1];
  logic                 vmm_q [NS+1];

  always_comb begin
    sx = cmd_q[NS] ? (ra_x[NS] - rb_x[NS]) : (ra_x[NS] + rb_x[NS]);
    sy = cmd_q[NS] ? (ra_y[NS] - rb_y[NS]) : (ra_y[NS] + rb_y[NS]);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (!sx[XW-1]) begin
        v_x[0] <= sx;
        v_y[0] <= sy;
        v_z[0] <= '0;
      end else if (!sy[XW-1]) begin
        v_x[0] <= sy;
        v_y[0] <= -sx;
        v_z[0] <= QuarterTurn;
      end else begin
        v_x[0] <= -sy;
        v_y[0] <= sx;
        v_z[0] <= -QuarterTurn;
      end
      vfq_q[0] <= fq_q[NS];
      vmm_q[0] <= mm_q[NS];
      for (int i = 1; i <= NS; i++) begin
        vfq_q[i] <= vfq_q[i-1];
        vmm_q[i] <= vmm_q[i-1];
      end
    end
  end

  // Vectoring chain
  for (genvar g = 0; g < NS; g++) begin : g_vec
    pas_cell #(.STEP(g), .VECTOR(1'b1)) u_cell_v (
      .clk_i, .en_i(en),
      .x_i(v_x[g]), .y_i(v_y[g]), .z_i(v_z[g]),
      .x_o(v_x[g+1]), .y_o(v_y[g+1]), .z_o(v_z[g+1])
    );
  end

  // Gain compensation of the magnitude
  logic [31:0]          xc;
  logic [61:0]          mprod;
  logic [31:0]          t_q;
  logic signed [ZW-1:0] tz_q;
  logic [AmpW-1:0]      tfq_q;
  logic                 tmm_q;

  always_comb begin
    xc    = v_x[NS][XW-1] ? 32'd0 : v_x[NS][31:0];
    mprod = 62'(xc) * 62'(InvGain);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      t_q   <= mprod[61:30];
      tz_q  <= v_z[NS];
      tfq_q <= vfq_q[NS];
      tmm_q <= vmm_q[NS];
    end
  end

  // Round, saturate, wrap phase, apply special cases
  logic [32:0]          tr;
  logic [26:0]          mag;
  logic [24:0]          mag_sat;
  logic signed [ZW-1:0] zr;
  logic [15:0]          zlow;
  logic signed [PhW-1:0] ph;
  logic [24:0]          amp_d, amp_q;
  logic [AmpW-1:0]      frq_d, frq_q;
  logic signed [PhW-1:0] ph_d, ph_q;
  logic                 mm_d, mm_out_q;

  always_comb begin
    tr      = {1'b0, t_q} + 33'd32;
    mag     = tr[32:GuardW];
    mag_sat = (mag > 27'd16777216) ? 25'd16777216 : mag[24:0];
    zr      = tz_q + 34'sd32768;
    zlow    = zr[31:16];
    ph      = (zlow > 16'd32768) ? {1'b1, zlow} : {1'b0, zlow};
    mm_d    = tmm_q;
    if (tmm_q) begin
      amp_d = '0;
      frq_d = '0;
      ph_d  = '0;
    end else begin
      amp_d = mag_sat;
      frq_d = tfq_q;
      ph_d  = (mag_sat == 25'd0) ? '0 : ph;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      amp_q    <= amp_d;
      frq_q    <= frq_d;
      ph_q     <= ph_d;
      mm_out_q <= mm_d;
    end
  end

  assign out_valid_o     = vld_q[NV-1];
  assign amp_out_o       = amp_q;
  assign freq_out_o      = frq_q;
  assign phase_out_o     = ph_q;
  assign freq_mismatch_o = mm_out_q;

endmodule

// ----- bench/tb_phasor_add_subtract.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_phasor_add_subtract
// Self-checking bench for the phasor adder: a directed table, then random
// phasor pairs, with results compared against a CORDIC model kept here.
// ----------------------------------------------------------------------------
module tb_phasor_add_subtract;
  import pas_pkg::*;

  localparam int unsigned Steps      = 16;
  localparam int unsigned UsedSteps  = (Steps > 24) ? 24 : Steps;
  localparam int          Latency    = 2 * UsedSteps + 5;
  localparam int          RandItems  = 750;
  localparam int          CycleLimit = 200000;
  localparam longint      Gain       = 652032874;
  localparam longint      Quarter    = 1073741824;
  localparam logic        CmdAdd     = 1'b0;
  localparam logic        CmdSub     = 1'b1;

  typedef struct {
    logic                   cmd;
    logic signed [23:0]     amp_a, freq_a;
    logic signed [15:0]     phase_a;
    logic signed [23:0]     amp_b, freq_b;
    logic signed [15:0]     phase_b;
  } pair_t;

  typedef struct {
    logic [24:0]            amp;
    logic [23:0]            freq;
    logic signed [16:0]     ph;
    logic                   mism;
  } phasor_res_t;

  typedef struct {
    pair_t                  p;
    bit                     typed;
    phasor_res_t            r;
  } row_t;

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    in_valid_i = 1'b0;
  logic                    in_stall_o;
  logic                    cmd_i = 1'b0;
  logic signed [23:0]      amp_a_i = '0, freq_a_i = '0, amp_b_i = '0, freq_b_i = '0;
  logic signed [15:0]      phase_a_i = '0, phase_b_i = '0;
  logic                    out_valid_o;
  logic                    out_stall_i = 1'b0;
  logic [24:0]             amp_out_o;
  logic [23:0]             freq_out_o;
  logic signed [16:0]      phase_out_o;
  logic                    freq_mismatch_o;

  phasor_res_t             pending_sums[$];
  int                      errors = 0;
  int                      cycles = 0;
  int                      sent = 0;
  bit                      hold_off_req = 1'b0;
  bit                      quiet_out = 1'b0;

  phasor_add_subtract #(.CORDIC_STEPS(Steps)) uut (.*);

  // Clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Arctangent of 2^-i, 2^32 units per turn
  function automatic longint arctan_step(int i);
    longint tab[24] = '{536870912, 316933406, 167458907, 85004756, 42667331,
                        21354465, 10679838, 5340245, 2670163, 1335087, 667544,
                        333772, 166886, 83443, 41722, 20861, 10430, 5215, 2608,
                        1304, 652, 326, 163, 81};
    return tab[i];
  endfunction

  function automatic longint wrap_turn(longint p);
    longint r;
    r = p & 64'hFFFF;
    if (r > 32768) r -= 65536;
    return r;
  endfunction

  // Fold negative frequency and amplitude sign into the phase
  function automatic void fold_operand(input logic signed [23:0] a, f,
                                       input logic signed [15:0] p,
                                       output longint mag, fmag, ph);
    longint pp;
    pp = p;
    if (f < 0) pp = -pp;
    if ((f < 0) != (a < 0)) pp += 32768;
    mag  = (a < 0) ? -longint'(a) : longint'(a);
    fmag = (f < 0) ? -longint'(f) : longint'(f);
    ph   = wrap_turn(pp);
  endfunction

  function automatic void polar_to_xy(input longint mag, ph, output longint xo, yo);
    longint a, z, x, y, dx, dy;
    a = ((mag <<< 6) * Gain) >>> 30;
    z = ph * 65536;
    x = a; y = 0;
    if (z > Quarter) begin
      x = 0; y = a; z -= Quarter;
    end else if (z < -Quarter) begin
      x = 0; y = -a; z += Quarter;
    end
    for (int i = 0; i < UsedSteps; i++) begin
      dx = y >>> i; dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= arctan_step(i);
      end else begin
        x += dx; y -= dy; z += arctan_step(i);
      end
    end
    xo = x; yo = y;
  endfunction

  function automatic void xy_to_polar(input longint xi, yi, output longint mag, ph);
    longint x, y, z, t, dx, dy;
    x = xi; y = yi; z = 0;
    if (x < 0) begin
      if (y >= 0) begin
        t = x; x = y; y = -t; z = Quarter;
      end else begin
        t = x; x = -y; y = t; z = -Quarter;
      end
    end
    for (int i = 0; i < UsedSteps; i++) begin
      dx = y >>> i; dy = x >>> i;
      if (y < 0) begin
        x -= dx; y += dy; z -= arctan_step(i);
      end else begin
        x += dx; y -= dy; z += arctan_step(i);
      end
    end
    if (x < 0) x = 0;
    t = (x * Gain) >>> 30;
    t = (t + 32) >>> 6;
    if (t > 16777216) t = 16777216;
    mag = t;
    ph  = wrap_turn((z + 32768) >>> 16);
  endfunction

  function automatic phasor_res_t phasor_sum(pair_t p);
    phasor_res_t r;
    longint am, af, ap, bm, bf, bp, xa, ya, xb, yb, mag, ph;
    fold_operand(p.amp_a, p.freq_a, p.phase_a, am, af, ap);
    fold_operand(p.amp_b, p.freq_b, p.phase_b, bm, bf, bp);
    r = '{amp: '0, freq: '0, ph: '0, mism: 1'b0};
    if (af != bf) begin
      r.mism = 1'b1;
      return r;
    end
    polar_to_xy(am, ap, xa, ya);
    polar_to_xy(bm, bp, xb, yb);
    if (p.cmd == CmdSub) begin
      xa -= xb; ya -= yb;
    end else begin
      xa += xb; ya += yb;
    end
    if (xa == 0 && ya == 0) begin
      mag = 0; ph = 0;
    end else begin
      xy_to_polar(xa, ya, mag, ph);
    end
    if (mag == 0) ph = 0;
    r.amp  = mag[24:0];
    r.freq = af[23:0];
    r.ph   = ph[16:0];
    return r;
  endfunction

  // Offer one transaction and hold it until accepted
  task automatic send_pair(pair_t p, bit typed, phasor_res_t r);
    in_valid_i <= 1'b1;
    cmd_i <= p.cmd;
    amp_a_i <= p.amp_a; freq_a_i <= p.freq_a; phase_a_i <= p.phase_a;
    amp_b_i <= p.amp_b; freq_b_i <= p.freq_b; phase_b_i <= p.phase_b;
    do @(posedge clk_i); while (in_stall_o);
    pending_sums.push_back(typed ? r : phasor_sum(p));
    sent++;
  endtask

  task automatic idle_sender(bit allow);
    if (allow && $urandom_range(99) < 15) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
  endtask

  function automatic logic signed [23:0] pick_value();
    case ($urandom_range(7))
      0: return 24'sh800000;
      1: return 24'sh7FFFFF;
      2: return 24'(signed'($urandom_range(0, 131072)) - 65536);
      default: return 24'($urandom);
    endcase
  endfunction

  function automatic pair_t random_pair();
    pair_t p;
    p.cmd     = $urandom_range(1) ? CmdSub : CmdAdd;
    p.amp_a   = pick_value();
    p.freq_a  = pick_value();
    p.phase_a = 16'($urandom);
    p.amp_b   = pick_value();
    p.phase_b = 16'($urandom);
    case ($urandom_range(9))
      0: p.freq_b = pick_value();
      1, 2, 3, 4: p.freq_b = -p.freq_a;
      default: p.freq_b = p.freq_a;
    endcase
    // Occasionally make B a copy of A so the result can cancel
    if ($urandom_range(19) == 0) begin
      p.amp_b = p.amp_a; p.freq_b = p.freq_a; p.phase_b = p.phase_a;
    end
    return p;
  endfunction

  // Stimulus
  initial begin
    row_t rows[$];
    phasor_res_t none;
    none = '{amp: '0, freq: '0, ph: '0, mism: 1'b0};
    // Zero operands, cancellation, frequency mismatch
    rows.push_back('{'{CmdAdd, 0, 0, 0, 0, 0, 0}, 1, '{0, 0, 0, 0}});
    rows.push_back('{'{CmdSub, 65536, 65536, 1234, 65536, 65536, 1234}, 1,
                     '{0, 65536, 0, 0}});
    rows.push_back('{'{CmdAdd, 65536, 65536, 0, 65536, 131072, 0}, 1, '{0, 0, 0, 1}});
    rows.push_back('{'{CmdSub, -5, -8388608, 7, 9, 8388607, -3}, 1, '{0, 0, 0, 1}});
    // Extremes of amplitude, frequency and phase
    rows.push_back('{'{CmdAdd, 24'sh7FFFFF, 24'sh7FFFFF, 32767, 24'sh7FFFFF,
                       24'sh7FFFFF, 32767}, 0, none});
    rows.push_back('{'{CmdAdd, 24'sh800000, 24'sh800000, -32768, 24'sh800000,
                       24'sh800000, -32768}, 0, none});
    rows.push_back('{'{CmdSub, 24'sh7FFFFF, 65536, -32768, 24'sh800000, 65536, 0},
                     0, none});
    rows.push_back('{'{CmdAdd, 24'sh7FFFFF, 24'sh800000, 16384, 24'sh7FFFFF,
                       24'sh800000, 16384}, 0, none});
    // Negative frequency, amplitude sign mismatch, phase landing on -pi
    rows.push_back('{'{CmdAdd, 65536, -65536, 8192, 65536, 65536, -8192}, 0, none});
    rows.push_back('{'{CmdAdd, -65536, 65536, 0, 65536, 65536, -32768}, 0, none});
    rows.push_back('{'{CmdSub, 100000, 30000, -16384, -100000, -30000, 16384},
                     0, none});
    rows.push_back('{'{CmdAdd, 65536, 65536, -32768, 0, 65536, 0}, 0, none});
    rows.push_back('{'{CmdSub, 1, 1, 0, 1, 1, 32767}, 0, none});
    rows.push_back('{'{CmdAdd, 1, 1, 16384, 1, 1, 16385}, 0, none});

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[i]) begin
      idle_sender(1'b1);
      send_pair(rows[i].p, rows[i].typed, rows[i].r);
    end

    for (int n = 0; n < RandItems; n++) begin
      // Let the output stall back up through the pipe
      if (n == 150) hold_off_req = 1'b1;
      // Drain everything once before resuming
      if (n == 450) begin
        in_valid_i <= 1'b0;
        while (pending_sums.size() != 0) @(posedge clk_i);
      end
      quiet_out = (n >= 300 && n < 420);
      idle_sender(!quiet_out);
      send_pair(random_pair(), 1'b0, none);
    end
    in_valid_i <= 1'b0;

    while (pending_sums.size() != 0) @(posedge clk_i);
    repeat (Latency + 10) @(posedge clk_i);
    if (errors == 0) begin
      $display("phasor_add_subtract regression: pass");
    end else begin
      $display("phasor_add_subtract regression: fail");
    end
    $finish;
  end

  // Output stall: random, plus one long hold-off when requested
  initial begin
    int hold;
    hold = 0;
    forever begin
      @(posedge clk_i);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        hold = 4 * Latency;
      end
      if (hold > 0) begin
        hold--;
        out_stall_i <= 1'b1;
      end else if (!quiet_out && $urandom_range(99) < 15) begin
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // Compare each delivered transaction with the oldest expectation
  always @(posedge clk_i) begin
    phasor_res_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_sums.size() == 0) begin
        $display("%0t: unexpected result amp=%0d freq=%0d ph=%0d mism=%0b", $time,
                 amp_out_o, freq_out_o, phase_out_o, freq_mismatch_o);
        errors++;
      end else begin
        e = pending_sums.pop_front();
        if (amp_out_o !== e.amp) begin
          $display("%0t: amp_out expected %0d got %0d", $time, e.amp, amp_out_o);
          errors++;
        end
        if (freq_out_o !== e.freq) begin
          $display("%0t: freq_out expected %0d got %0d", $time, e.freq, freq_out_o);
          errors++;
        end
        if (phase_out_o !== e.ph) begin
          $display("%0t: phase_out expected %0d got %0d", $time, e.ph, phase_out_o);
          errors++;
        end
        if (freq_mismatch_o !== e.mism) begin
          $display("%0t: freq_mismatch expected %0b got %0b", $time, e.mism,
                   freq_mismatch_o);
          errors++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("phasor_add_subtract regression: fail");
      $finish;
    end
  end

endmodule
